// ===== hw/rtl/bcml_pkg.sv =====
// ----------------------------------------------------------------------------
// bcml_pkg
// Shared types and constants for the bounded compacting message list.
// ----------------------------------------------------------------------------
package bcml_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int HDL_W   = 16;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_ADD        = 2'd0,
		OP_DEL_HANDLE = 2'd1,
		OP_DEL_INDEX  = 2'd2,
		OP_READ       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_NEW  = 2'd1,
		EV_DEL  = 2'd2
	} event_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// ===== hw/rtl/bcml_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcml_ctrl
// Controller: sequences capture and execution of one word and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module bcml_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output bcml_pkg::cmd_t cmd
);
	import bcml_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// A new word is only taken once the result register will be free by the
	// time execution loads it.
	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = out_valid_q && out_stall;
				cmd.capture = in_valid && !(out_valid_q && out_stall);
			end
			ST_EXEC: cmd.execute = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/bcml_datapath.sv =====
// ----------------------------------------------------------------------------
// bcml_datapath
// Slot row with parallel compare and one-place compaction, plus the
// input capture and result registers.
// ----------------------------------------------------------------------------
module bcml_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bcml_pkg::cmd_t                    cmd,
	input  logic [1:0]                        op,
	input  logic [bcml_pkg::HDL_W-1:0]        handle,
	input  logic [bcml_pkg::POS_W-1:0]        position,
	output logic                              ok,
	output logic [bcml_pkg::HDL_W-1:0]        read_handle,
	output logic [bcml_pkg::COUNT_W-1:0]      count,
	output logic [1:0]                        event_res
);
	import bcml_pkg::*;

	op_t                op_q;
	logic [HDL_W-1:0]   handle_q;
	logic [POS_W-1:0]   pos_q;
	logic [HDL_W-1:0]   slot_q [SLOTS];
	logic [CNT_W-1:0]   cnt_q;

	logic               ok_q;
	logic [HDL_W-1:0]   rd_q;
	logic [CNT_W-1:0]   res_cnt_q;
	event_t             ev_q;

	logic [SLOTS-1:0]   match;
	logic [SLOTS-1:0]   first;
	logic [SLOTS-1:0]   from_first;
	logic [SLOTS-1:0]   shift_mask;
	logic               full;
	logic               pos_ok;
	logic               found;
	logic               do_shift;
	logic               do_write;
	logic [IDX_W-1:0]   wr_idx;
	logic [HDL_W-1:0]   slot_d [SLOTS];
	logic [CNT_W-1:0]   cnt_d;
	logic               ok_d;
	logic [HDL_W-1:0]   rd_d;
	event_t             ev_d;

	assign full   = (cnt_q == CNT_W'(SLOTS));
	assign pos_ok = (CNT_W'(pos_q) < cnt_q);

	// Each cell compares its own handle; stale entries above the fill level
	// are masked out.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (slot_q[i] == handle_q);
		end
	end

	assign found      = (handle_q != '0) && (match != '0);
	assign first      = match & (~match + SLOTS'(1));
	assign from_first = ~(first - SLOTS'(1));

	always_comb begin
		shift_mask = '0;
		do_shift   = 1'b0;
		do_write   = 1'b0;
		cnt_d      = cnt_q;
		ok_d       = 1'b0;
		rd_d       = '0;
		ev_d       = EV_NONE;
		unique case (op_q)
			OP_ADD: begin
				do_write = 1'b1;
				ok_d     = 1'b1;
				ev_d     = EV_NEW;
				if (full) begin
					do_shift   = 1'b1;
					shift_mask = '1;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_DEL_HANDLE: begin
				if (found) begin
					do_shift   = 1'b1;
					shift_mask = from_first;
					cnt_d      = cnt_q - CNT_W'(1);
					ok_d       = 1'b1;
					ev_d       = EV_DEL;
				end
			end
			OP_DEL_INDEX: begin
				if (pos_ok) begin
					do_shift = 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						shift_mask[i] = (CNT_W'(i) >= CNT_W'(pos_q));
					end
					cnt_d = cnt_q - CNT_W'(1);
					ok_d  = 1'b1;
					ev_d  = EV_DEL;
				end
			end
			OP_READ: begin
				if (pos_ok) begin
					ok_d = 1'b1;
					rd_d = slot_q[IDX_W'(pos_q)];
				end
			end
			default: ok_d = 1'b0;
		endcase
	end

	// When full, the add lands in the last cell after the row has moved up.
	assign wr_idx = full ? IDX_W'(SLOTS - 1) : cnt_q[IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_d[i] = slot_q[i];
			if (do_shift && shift_mask[i] && (i < SLOTS - 1)) begin
				slot_d[i] = slot_q[(i + 1) % SLOTS];
			end
			if (do_write && (wr_idx == IDX_W'(i))) begin
				slot_d[i] = handle_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(op);
			handle_q <= handle;
			pos_q    <= position;
		end
		if (cmd.execute) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_q[i] <= slot_d[i];
			end
			ok_q      <= ok_d;
			rd_q      <= rd_d;
			res_cnt_q <= cnt_d;
			ev_q      <= ev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.execute) begin
			cnt_q <= cnt_d;
		end
	end

	assign ok          = ok_q;
	assign read_handle = rd_q;
	assign count       = COUNT_W'(res_cnt_q);
	assign event_res   = ev_q;

endmodule

// ===== hw/rtl/bounded_compacting_message_list.sv =====
// ----------------------------------------------------------------------------
// bounded_compacting_message_list
// Ordered list of up to sixteen message handles with add, delete and read.
// ----------------------------------------------------------------------------
// Each word is first captured and then executed: the whole slot row compares
// against the handle in parallel, closes up the gap by one place and loads
// the result register, so the block takes no new word while one is being
// executed. A waiting result is held in its own register and the next word
// is taken as soon as that register is being emptied.
module bounded_compacting_message_list (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   op,
	input  logic [bcml_pkg::HDL_W-1:0]   handle,
	input  logic [bcml_pkg::POS_W-1:0]   position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         ok,
	output logic [bcml_pkg::HDL_W-1:0]   read_handle,
	output logic [bcml_pkg::COUNT_W-1:0] count,
	output logic [1:0]                   event_res
);
	import bcml_pkg::*;

	cmd_t cmd;

	bcml_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bcml_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.handle      (handle),
		.position    (position),
		.ok          (ok),
		.read_handle (read_handle),
		.count       (count),
		.event_res   (event_res)
	);

endmodule

// ===== hw/rtl/bcml_checker.sv =====
// ----------------------------------------------------------------------------
// bcml_checker
// Port-level checks for the bounded compacting message list.
// ----------------------------------------------------------------------------
module bcml_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         ok,
	input logic [bcml_pkg::HDL_W-1:0]   read_handle,
	input logic [bcml_pkg::COUNT_W-1:0] count,
	input logic [1:0]                   event_res
);
	import bcml_pkg::*;

	// A stalled result word must be held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(read_handle)
			&& $stable(count) && $stable(event_res))
		else $error("stalled result word changed");

	// A failed operation reports no event.
	a_fail_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> (event_res == EV_NONE) && (read_handle == '0))
		else $error("failed operation reported an event or handle");

	// A returned handle only comes from a successful read.
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_handle != '0) |-> ok && (event_res == EV_NONE))
		else $error("handle returned outside a read");

	// After an add the list cannot be empty; the count never exceeds the slots.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= COUNT_W'(SLOTS))
			&& ((event_res != EV_NEW) || (count != '0)))
		else $error("count out of range");

endmodule

bind bounded_compacting_message_list bcml_checker u_bcml_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.ok          (ok),
	.read_handle (read_handle),
	.count       (count),
	.event_res   (event_res)
);

// ===== bench/msg_list_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msg_list_check_pkg
// Shadow copy of the message list and the queue of results it predicts.
// Every accepted input word updates the shadow list and queues one expected
// result. Each result taken from the block is checked against the oldest
// expected result, field by field.
// ----------------------------------------------------------------------------
package msg_list_check_pkg;

	import bcml_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [HDL_W-1:0]   read_handle;
		logic [COUNT_W-1:0] count;
		event_t             event_res;
	} list_result_t;

	class msg_list_checker;
		logic [HDL_W-1:0] shadow_slots [SLOTS];
		int               shadow_fill;
		list_result_t     awaited_results [$];
		int               errors;

		function new();
			foreach (shadow_slots[i]) shadow_slots[i] = '0;
			shadow_fill = 0;
			errors = 0;
		endfunction

		// Drops one entry; everything behind it moves up a place.
		function void close_gap(int idx);
			for (int i = idx + 1; i < shadow_fill; i++)
				shadow_slots[i - 1] = shadow_slots[i];
			shadow_fill--;
		endfunction

		function void apply_word(op_t w_op, logic [HDL_W-1:0] w_handle,
				logic [POS_W-1:0] w_pos);
			list_result_t r;
			r.ok = 1'b0;
			r.read_handle = '0;
			r.event_res = EV_NONE;
			case (w_op)
				OP_ADD: begin
					// A full list loses its oldest entry without a delete event.
					if (shadow_fill >= SLOTS)
						close_gap(0);
					shadow_slots[shadow_fill] = w_handle;
					shadow_fill++;
					r.ok = 1'b1;
					r.event_res = EV_NEW;
				end
				OP_DEL_HANDLE: begin
					// Handle zero never matches, even when a zero is stored.
					if (w_handle != '0) begin
						for (int i = 0; i < shadow_fill; i++) begin
							if (shadow_slots[i] == w_handle) begin
								close_gap(i);
								r.ok = 1'b1;
								r.event_res = EV_DEL;
								break;
							end
						end
					end
				end
				OP_DEL_INDEX: begin
					if (w_pos < shadow_fill) begin
						close_gap(w_pos);
						r.ok = 1'b1;
						r.event_res = EV_DEL;
					end
				end
				default: begin
					if (w_pos < shadow_fill) begin
						r.ok = 1'b1;
						r.read_handle = shadow_slots[w_pos];
					end
				end
			endcase
			r.count = COUNT_W'(shadow_fill);
			awaited_results.push_back(r);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		function void compare_result(list_result_t got);
			list_result_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h",
					$time, got);
				return;
			end
			want = awaited_results.pop_front();
			report("ok", want.ok, got.ok);
			report("read_handle", want.read_handle, got.read_handle);
			report("count", want.count, got.count);
			report("event_res", want.event_res, got.event_res);
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the bounded compacting message list.
// A short directed sequence covers the empty and full list, zero handles and
// the highest position; three random phases follow with differing idle rates
// on either side, a long output hold-off and a pause until the block drains.
// ----------------------------------------------------------------------------
module tb_top;

	import bcml_pkg::*;
	import msg_list_check_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int LIMIT_CYCLES    = 300000;
	localparam int WORDS_PER_PHASE = 500;
	localparam int HOLD_CYCLES     = 200;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	op_t                op = OP_ADD;
	logic [HDL_W-1:0]   handle = '0;
	logic [POS_W-1:0]   position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               ok;
	logic [HDL_W-1:0]   read_handle;
	logic [COUNT_W-1:0] count;
	logic [1:0]         event_res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int cycles = 0;

	msg_list_checker tracker;

	bounded_compacting_message_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.handle      (handle),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.read_handle (read_handle),
		.count       (count),
		.event_res   (event_res)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin : watchdog
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Result side: checks every word taken and decides the next stall.
	initial begin : receiver
		int           hold_left;
		list_result_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					got.ok = ok;
					got.read_handle = read_handle;
					got.count = count;
					got.event_res = event_t'(event_res);
					tracker.compare_result(got);
				end
				if (hold_request > 0) begin
					hold_left = hold_request;
					hold_request = 0;
				end
				if (hold_left > 0) begin
					out_stall <= 1'b1;
					hold_left--;
				end else begin
					out_stall <= ($urandom_range(99) < recv_idle_pct);
				end
			end
		end
	end

	task automatic send_word(op_t w_op, logic [HDL_W-1:0] w_handle,
			logic [POS_W-1:0] w_pos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w_op;
		handle <= w_handle;
		position <= w_pos;
		do @(posedge clk); while (in_stall);
		tracker.apply_word(w_op, w_handle, w_pos);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Half the handles are taken from the list itself when it is not empty, so that
	// deletes hit and duplicates arise; the rest are zero, small values from 1 to 6 or anything.
	task automatic random_word(int add_pct);
		op_t              w_op;
		logic [HDL_W-1:0] w_handle;
		logic [POS_W-1:0] w_pos;
		int               roll;
		if ($urandom_range(99) < add_pct) begin
			w_op = OP_ADD;
		end else begin
			case ($urandom_range(2))
				0:       w_op = OP_DEL_HANDLE;
				1:       w_op = OP_DEL_INDEX;
				default: w_op = OP_READ;
			endcase
		end
		roll = $urandom_range(99);
		if (tracker.shadow_fill > 0 && roll < 50)
			w_handle = tracker.shadow_slots[$urandom_range(tracker.shadow_fill - 1)];
		else if (roll < 65)
			w_handle = '0;
		else if (roll < 80)
			w_handle = HDL_W'($urandom_range(6, 1));
		else
			w_handle = HDL_W'($urandom());
		if (tracker.shadow_fill > 0 && $urandom_range(99) < 70)
			w_pos = POS_W'($urandom_range(tracker.shadow_fill - 1));
		else
			w_pos = POS_W'($urandom());
		send_word(w_op, w_handle, w_pos);
	endtask

	// The add rate is drawn anew every 25 words so the list swings between
	// nearly empty and overflowing.
	task automatic run_phase(int words, bit with_hold, bit with_drain);
		int add_pct;
		add_pct = 50;
		for (int n = 0; n < words; n++) begin
			if (n % 25 == 0) begin
				case ($urandom_range(2))
					0:       add_pct = 25;
					1:       add_pct = 50;
					default: add_pct = 85;
				endcase
			end
			if (with_hold && n == words / 4)
				hold_request = HOLD_CYCLES;
			if (with_drain && n == words / 2)
				wait_for_drain();
			random_word(add_pct);
		end
	endtask

	initial begin : main
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every removal and read fails.
		send_word(OP_READ, '0, 4'd0);
		send_word(OP_DEL_INDEX, '0, 4'd0);
		send_word(OP_DEL_HANDLE, '0, '0);
		// A zero handle is stored but can never be deleted by value.
		send_word(OP_ADD, '0, '0);
		send_word(OP_DEL_HANDLE, '0, '0);
		send_word(OP_READ, '0, 4'd1);
		send_word(OP_DEL_HANDLE, 16'hBEEF, '0);
		// Fill to capacity, then one more add pushes out the oldest entry.
		send_word(OP_ADD, 16'hFFFF, '0);
		for (int b = 0; b < 14; b++)
			send_word(OP_ADD, HDL_W'(1) << b, POS_W'(b));
		send_word(OP_ADD, 16'hA5A5, 4'hF);
		send_word(OP_READ, '0, 4'hF);
		send_word(OP_DEL_INDEX, '0, 4'hF);
		send_word(OP_DEL_HANDLE, 16'hFFFF, '0);

		send_idle_pct = 24;
		recv_idle_pct = 77;
		run_phase(WORDS_PER_PHASE, 1'b1, 1'b0);
		send_idle_pct = 77;
		recv_idle_pct = 24;
		run_phase(WORDS_PER_PHASE, 1'b0, 1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(WORDS_PER_PHASE, 1'b1, 1'b0);

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
